// ----- rtl/core/lufpp_pkg.sv -----
// Package: shared types and constants for the LU factorizer
`timescale 1ns / 1ps
package lufpp_pkg;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         row_res;
    logic [2:0]         col_res;
    logic signed [31:0] value_res;
    logic [2:0]         orig_row;
    logic               singular;
    logic               saturated;
    logic               last_res;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_SCAN,
    ST_PIV_DONE,
    ST_SWAP_RDA,
    ST_SWAP_RDB,
    ST_SWAP_WRA,
    ST_SWAP_WRB,
    ST_ROW_START,
    ST_DIV_RD,
    ST_DIV_RUN,
    ST_DIV_WR,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_WR,
    ST_EMIT_RD,
    ST_EMIT_HOLD,
    ST_CLEAR
  } state_t;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  // Clamp a 66-bit signed value to 32 bits, report clamping.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) r = {1'b1, SAT_MAX};
    else if (v < -66'sd2147483648) r = {1'b1, SAT_MIN};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ----- rtl/core/lu_factorizer_partial_pivot.sv -----
// Top level: LU factorization with partial pivoting over a one-read, one-write-port matrix memory
`timescale 1ns / 1ps
// Loading: one cycle per element transaction; the block is sequential, one job at a time.
// After the last element the job runs through the matrix memory's one read and one write port:
// pivot scan, row swap (read both elements, write both back), a 48-step serial division per
// multiplier (with its read and write-back) and a read, multiply and write per trailing update.
// Emission reads and holds each element in turn, then a clearing sweep restores zeros in all 64 words.
// Synchronous active-low reset clears control, then a clearing pass over all 64 words; no loads.
module lu_factorizer_partial_pivot #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lufpp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lufpp_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata
);
  import lufpp_pkg::*;

  localparam int DEPTH = 64;

  // matrix memory, address {row,col}
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_q;
  logic [5:0]  ra, wa;
  logic        we;
  logic signed [31:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic [3:0] order_r;
  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= 4'd8;
    else if (cfg_we) order_r <= cfg_wdata;
  end

  state_t st_r, st_nxt;
  logic [2:0] n1_r;            // order - 1
  logic [2:0] k_r, i_r, j_r, piv_r;
  logic [31:0] best_r;
  logic signed [31:0] a_r, p_r, m_r;
  logic signed [63:0] prod_r;
  logic [2:0] orig_r [MAX_ORDER];
  logic sing_r, sat_r;
  logic [5:0] clr_r;

  logic dv_start, dv_done, dv_sat;
  logic signed [31:0] dv_q;
  logic dv_go_r;

  // dividend comes straight from the memory read of the row below the pivot
  lufpp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(rd_q), .den(p_r),
    .done(dv_done), .quo(dv_q), .sat(dv_sat)
  );

  logic in_acc, in_ok;
  assign in_acc = in_valid && in_ready;
  assign in_ok  = (32'(in_data.row) < MAX_ORDER) && (32'(in_data.col) < MAX_ORDER);

  logic [31:0] mag;
  assign mag = rd_q[31] ? 32'(-33'(rd_q)) : rd_q;

  logic signed [65:0] upd_full;
  logic [32:0] upd_s;
  always_comb begin
    upd_full = 66'(rd_q) - 66'(prod_r >>> FRAC_BITS);
    upd_s    = sat32(upd_full);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD:      if (in_acc && in_data.last)
                      st_nxt = (order_r <= 4'd1) ? ST_EMIT_RD : ST_PIV_RD;
      ST_PIV_RD:    st_nxt = ST_PIV_SCAN;
      ST_PIV_SCAN:  if (i_r == n1_r) st_nxt = ST_PIV_DONE; else st_nxt = ST_PIV_SCAN;
      ST_PIV_DONE:  st_nxt = (best_r == 0 && mag == 0) ? ST_EMIT_RD : ST_SWAP_RDA;
      ST_SWAP_RDA:  st_nxt = ST_SWAP_RDB;
      ST_SWAP_RDB:  st_nxt = ST_SWAP_WRA;
      ST_SWAP_WRA:  st_nxt = ST_SWAP_WRB;
      ST_SWAP_WRB:  st_nxt = (j_r == n1_r) ? ST_ROW_START : ST_SWAP_RDA;
      ST_ROW_START: st_nxt = ST_DIV_RD;
      ST_DIV_RD:    st_nxt = ST_DIV_RUN;
      ST_DIV_RUN:   if (dv_done) st_nxt = ST_DIV_WR;
      ST_DIV_WR:    st_nxt = ST_UPD_RD;
      ST_UPD_RD:    st_nxt = ST_UPD_MUL;
      ST_UPD_MUL:   st_nxt = ST_UPD_WR;
      ST_UPD_WR: begin
        if (j_r != n1_r) st_nxt = ST_UPD_RD;
        else if (i_r != n1_r) st_nxt = ST_DIV_RD;
        else if (k_r + 3'd1 != n1_r) st_nxt = ST_PIV_RD;
        else st_nxt = ST_EMIT_RD;
      end
      ST_EMIT_RD:   st_nxt = ST_EMIT_HOLD;
      ST_EMIT_HOLD: if (out_ready) st_nxt = (i_r == n1_r && j_r == n1_r) ? ST_CLEAR : ST_EMIT_RD;
      ST_CLEAR:     if (clr_r == 6'(DEPTH - 1)) st_nxt = ST_LOAD;
      default:      st_nxt = ST_CLEAR;
    endcase
  end

  // memory addresses and control outputs
  always_comb begin
    ra = {i_r, k_r};
    wa = {in_data.row, in_data.col};
    we = 1'b0;
    wd = in_data.value;
    dv_start  = 1'b0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        we = in_valid && in_ok;
      end
      ST_PIV_RD: ra = {k_r, k_r};
      ST_PIV_SCAN: ra = {i_r, k_r};
      ST_SWAP_RDA: ra = {k_r, j_r};
      ST_SWAP_RDB: ra = {piv_r, j_r};
      ST_SWAP_WRA: begin we = 1'b1; wa = {k_r, j_r}; wd = rd_q; end
      ST_SWAP_WRB: begin we = 1'b1; wa = {piv_r, j_r}; wd = a_r; end
      ST_ROW_START: ra = {k_r, k_r};
      ST_DIV_RD: ra = {i_r, k_r};
      // pulse start on the first cycle, while the dividend sits on the read port
      ST_DIV_RUN: dv_start = !dv_go_r;
      ST_DIV_WR: begin we = 1'b1; wa = {i_r, k_r}; wd = m_r; end
      ST_UPD_RD: ra = {k_r, j_r};
      ST_UPD_MUL: ra = {i_r, j_r};
      ST_UPD_WR: begin we = 1'b1; wa = {i_r, j_r}; wd = upd_s[31:0]; end
      ST_EMIT_RD: ra = {i_r, j_r};
      // keep re-reading the same element so the payload holds while stalled
      ST_EMIT_HOLD: begin ra = {i_r, j_r}; out_valid = 1'b1; end
      ST_CLEAR: begin we = 1'b1; wa = clr_r; wd = '0; end
      default: ra = {i_r, k_r};
    endcase
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
      clr_r <= '0;
      sing_r <= 1'b0;
      sat_r <= 1'b0;
      dv_go_r <= 1'b0;
      k_r <= '0; i_r <= '0; j_r <= '0; piv_r <= '0; n1_r <= '0;
      for (int t = 0; t < MAX_ORDER; t++) orig_r[t] <= 3'(t);
    end else begin
      st_r <= st_nxt;
      dv_go_r <= (st_r == ST_DIV_RUN);
      unique case (st_r)
        ST_LOAD: if (in_acc && in_data.last) begin
          if (order_r == 4'd0) n1_r <= 3'd0;
          else if (32'(order_r) > MAX_ORDER) n1_r <= 3'(MAX_ORDER - 1);
          else n1_r <= 3'(order_r - 4'd1);
          k_r <= '0; i_r <= '0; j_r <= '0;
        end
        ST_PIV_RD: begin
          i_r <= k_r + 3'd1; best_r <= '0; piv_r <= k_r;
        end
        ST_PIV_SCAN: begin
          if (mag > best_r) begin best_r <= mag; piv_r <= i_r - 3'd1; end
          if (i_r != n1_r) i_r <= i_r + 3'd1;
        end
        ST_PIV_DONE: begin
          // rd_q now holds the last row's entry
          j_r <= '0;
          if (mag > best_r) begin best_r <= mag; piv_r <= n1_r; end
          // all-zero pivot column: stop and emit from the top
          if (best_r == 0 && mag == 0) begin
            sing_r <= 1'b1;
            i_r <= '0;
          end
          if (piv_r != k_r || mag > best_r) begin
            orig_r[k_r] <= orig_r[(mag > best_r) ? n1_r : piv_r];
            orig_r[(mag > best_r) ? n1_r : piv_r] <= orig_r[k_r];
          end
        end
        ST_SWAP_RDB: a_r <= rd_q;
        ST_SWAP_WRB: if (j_r != n1_r) j_r <= j_r + 3'd1;
        ST_ROW_START: i_r <= k_r + 3'd1;
        ST_DIV_RUN: if (dv_done) begin
          m_r <= dv_q;
          if (dv_sat) sat_r <= 1'b1;
        end
        ST_DIV_WR: j_r <= k_r + 3'd1;
        ST_UPD_MUL: prod_r <= m_r * rd_q;
        ST_UPD_WR: begin
          if (upd_s[32]) sat_r <= 1'b1;
          if (j_r != n1_r) j_r <= j_r + 3'd1;
          else if (i_r != n1_r) i_r <= i_r + 3'd1;
          else if (k_r + 3'd1 != n1_r) k_r <= k_r + 3'd1;
          else begin i_r <= '0; j_r <= '0; end
        end
        ST_EMIT_HOLD: if (out_ready) begin
          if (j_r != n1_r) j_r <= j_r + 3'd1;
          else begin j_r <= '0; i_r <= i_r + 3'd1; end
        end
        ST_CLEAR: begin
          clr_r <= clr_r + 6'd1;
          sing_r <= 1'b0;
          sat_r <= 1'b0;
          for (int t = 0; t < MAX_ORDER; t++) orig_r[t] <= 3'(t);
        end
        default: ;
      endcase
    end
  end

  // latch the pivot on the first row below it
  always_ff @(posedge clk) begin
    if (st_r == ST_DIV_RD && i_r == k_r + 3'd1) p_r <= rd_q;
  end

  // result fields: counters and flags hold while the transaction waits
  always_comb begin
    out_data.row_res   = i_r;
    out_data.col_res   = j_r;
    out_data.value_res = rd_q;
    out_data.orig_row  = orig_r[i_r];
    out_data.singular  = sing_r;
    out_data.saturated = sat_r;
    out_data.last_res  = (i_r == n1_r) && (j_r == n1_r);
  end

  // Check: no loads outside the load state, no result during clearing, no result dropped while stalled.
  a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == ST_LOAD) else $error("ready outside load");
  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLEAR |-> !out_valid) else $error("result during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

// ----- rtl/core/lufpp_div.sv -----
// Iterative signed divider: one quotient bit per cycle, truncation toward zero
`timescale 1ns / 1ps
module lufpp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo,
  output logic               sat
);
  import lufpp_pkg::*;

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_r, n_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [31:0]   d_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [NW:0]   trial;
  logic signed [65:0] q_s;
  logic [32:0]   st;
  logic [31:0]   nmag;

  assign nmag = 32'(num[31] ? -33'(num) : 33'(num));

  always_comb begin
    trial   = {rem_r[NW-1:0], n_r[NW-1]};
    rem_nxt = trial;
    n_nxt   = {n_r[NW-2:0], 1'b0};
    if (trial >= {{(NW-31){1'b0}}, d_r}) begin
      rem_nxt  = trial - {{(NW-31){1'b0}}, d_r};
      n_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {nmag, {FRAC_BITS{1'b0}}};
      d_r   <= den[31] ? 32'(-33'(den)) : den;
      rem_r <= '0;
      neg_r <= num[31] ^ den[31];
    end else if (busy_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = busy_r && (cnt_r == CW'(1));
  always_comb begin
    q_s = neg_r ? -$signed({1'b0, 65'(n_nxt)}) : $signed({1'b0, 65'(n_nxt)});
    st  = sat32(q_s);
  end
  assign quo = st[31:0];
  assign sat = st[32];
endmodule

// ----- tb/tb_lu_factorizer_partial_pivot.sv -----
// Testbench for the LU factorizer with partial pivoting: random and directed jobs
`timescale 1ns / 1ps
module tb_lu_factorizer_partial_pivot;
  import lufpp_pkg::*;

  localparam int NMAX = 8;
  localparam int FRAC = 16;

  // Scoreboard: shadow copy of the working matrix, factorizes on the last
  // load and queues the packed LU elements it expects to see.
  class lu_scoreboard;
    logic signed [31:0] mat [NMAX][NMAX];
    logic [2:0]         origin [NMAX];
    bit                 sing_flag;
    bit                 sat_flag;
    logic [3:0]         order_reg;
    out_item_t          lu_expected [$];
    int                 mismatches;

    function new();
      order_reg = 4'd8;
      mismatches = 0;
      clear_job();
    endfunction

    function void clear_job();
      for (int i = 0; i < NMAX; i++) begin
        origin[i] = i[2:0];
        for (int j = 0; j < NMAX; j++) mat[i][j] = '0;
      end
      sing_flag = 0;
      sat_flag = 0;
    endfunction

    function logic signed [31:0] clamp(input longint v);
      if (v > 64'sd2147483647) begin
        sat_flag = 1;
        return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
        sat_flag = 1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    function void factorize(input int n);
      longint best, m, num, prod, p;
      int piv;
      logic signed [31:0] t;
      logic [2:0] to;
      logic signed [31:0] mult;
      for (int k = 0; k < n - 1; k++) begin
        best = 0;
        piv = k;
        for (int i = k; i < n; i++) begin
          m = mat[i][k];
          if (m < 0) m = -m;
          if (m > best) begin
            best = m;
            piv = i;
          end
        end
        if (best == 0) begin
          sing_flag = 1;
          return;
        end
        if (piv != k) begin
          for (int j = 0; j < NMAX; j++) begin
            t = mat[k][j];
            mat[k][j] = mat[piv][j];
            mat[piv][j] = t;
          end
          to = origin[k];
          origin[k] = origin[piv];
          origin[piv] = to;
        end
        for (int i = k + 1; i < n; i++) begin
          num = longint'(mat[i][k]) * (longint'(1) << FRAC);
          mult = clamp(num / longint'(mat[k][k]));
          mat[i][k] = mult;
          for (int j = k + 1; j < n; j++) begin
            p = longint'(mult) * longint'(mat[k][j]);
            // arithmetic shift floors toward minus infinity
            prod = p >>> FRAC;
            mat[i][j] = clamp(longint'(mat[i][j]) - prod);
          end
        end
      end
    endfunction

    function void note_load(input in_item_t it);
      int n;
      out_item_t o;
      mat[it.row][it.col] = it.value;
      if (!it.last) return;
      n = order_reg;
      if (n < 1) n = 1;
      if (n > NMAX) n = NMAX;
      factorize(n);
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          o.row_res = i[2:0];
          o.col_res = j[2:0];
          o.value_res = mat[i][j];
          o.orig_row = origin[i];
          o.singular = sing_flag;
          o.saturated = sat_flag;
          o.last_res = (i == n - 1 && j == n - 1);
          lu_expected.push_back(o);
        end
      clear_job();
    endfunction

    task check_result(input out_item_t got);
      out_item_t e;
      if (lu_expected.size() == 0) begin
        report_mismatch("unexpected result transaction");
        return;
      end
      e = lu_expected.pop_front();
      if (got.row_res !== e.row_res) report_mismatch("row_res");
      if (got.col_res !== e.col_res) report_mismatch("col_res");
      if (got.value_res !== e.value_res) report_mismatch("value_res");
      if (got.orig_row !== e.orig_row) report_mismatch("orig_row");
      if (got.singular !== e.singular) report_mismatch("singular");
      if (got.saturated !== e.saturated) report_mismatch("saturated");
      if (got.last_res !== e.last_res) report_mismatch("last_res");
    endtask

    task report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [3:0] cfg_wdata;

  lu_scoreboard lu_sb;
  int  idle_pct;       // percent of cycles each side idles
  bit  hold_off;       // receiver long stall request
  bit  stim_done;

  lu_factorizer_partial_pivot uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Generous ceiling: 64 results per job each with long stalls, plus the
  // job run and clear sweep; several times the slowest sane run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random ready, plus a long hold-off when requested.
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Check every accepted result transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) lu_sb.check_result(out_data);
  end

  // Send one load transaction; idle gaps happen before valid rises. Valid
  // drops after the last element, otherwise the next call takes over.
  task automatic send_load(input logic [2:0] r, input logic [2:0] c,
                           input logic signed [31:0] v, input bit lst);
    in_item_t it;
    it.row = r;
    it.col = c;
    it.value = v;
    it.last = lst;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    lu_sb.note_load(it);
    if (lst) in_valid <= 1'b0;
  endtask

  // Wait until all expected results have drained, then let the clear sweep end.
  task automatic drain_results();
    while (lu_sb.lu_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Write the order register while idle.
  task automatic set_order(input logic [3:0] n);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    lu_sb.order_reg = n;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return 32'sd0;
      default: return $signed($urandom_range(32'h40000)) - 32'sh20000;
    endcase
  endfunction

  // Load a full n x n matrix in row-major order of fill, last on final element.
  task automatic load_matrix(input int n, input int style);
    logic signed [31:0] v;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        case (style)
          0: v = rand_value();
          1: v = (j == 0) ? 32'sd0 : rand_value();     // zero pivot column
          default: v = $signed($urandom_range(32'h60000)) - 32'sh30000;
        endcase
        send_load(i[2:0], j[2:0], v, (i == n - 1 && j == n - 1));
      end
  endtask

  initial begin
    int n;
    lu_sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_wdata = '0;
    idle_pct = 33;
    hold_off = 0;
    stim_done = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default order 8 job from a single last load (rest read as zero,
    // so singular), then order 1, extremes, order 0, an out-of-range order and a zero column.
    send_load(3'd7, 3'd7, 32'sh7fffffff, 1'b1);
    set_order(4'd1);
    send_load(3'd0, 3'd0, 32'sh80000000, 1'b1);
    set_order(4'd2);
    send_load(3'd0, 3'd0, 32'sd1, 1'b0);
    send_load(3'd1, 3'd0, 32'sh7fffffff, 1'b0);
    send_load(3'd0, 3'd1, 32'sh80000000, 1'b0);
    send_load(3'd1, 3'd1, 32'sh00010000, 1'b1);   // forces a row swap
    set_order(4'd0);                               // used as order 1
    send_load(3'd0, 3'd0, 32'sh00020000, 1'b1);
    set_order(4'd15);                              // clamped to 8
    send_load(3'd2, 3'd5, 32'sh12345678, 1'b1);
    set_order(4'd3);
    load_matrix(3, 1);

    // Pressure: stall the receiver while a job's results back up and the
    // next job's loads wait at the input.
    set_order(4'd4);
    fork
      begin
        hold_off = 1;
        repeat (800) @(posedge clk);
        hold_off = 0;
      end
      begin
        load_matrix(4, 2);
        load_matrix(4, 2);
      end
    join
    // Random jobs; one stretch runs with no idling.
    for (int jb = 0; jb < 13; jb++) begin
      n = (jb % 5 == 4) ? 8 : $urandom_range(2, 4);
      idle_pct = (jb >= 5 && jb < 8) ? 0 : 33;
      set_order(n[3:0]);
      load_matrix(n, (jb % 3 == 0) ? 0 : 2);
    end
    idle_pct = 33;
    drain_results();
    if (lu_sb.mismatches == 0 && lu_sb.lu_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
